// File: src/scct_pkg.sv
// Shared constants, types and command/status structs for the sector cache tag engine.
package scct_pkg;

  localparam int unsigned SLOTS        = 64;
  localparam int unsigned SLOT_W       = $clog2(SLOTS);
  localparam int unsigned SECTOR_W     = 32;
  localparam int unsigned SLOT_FIELD_W = 6;
  localparam int unsigned OP_W         = 2;
  localparam int unsigned RESULT_LIMIT = 64;
  localparam int unsigned CNT_W        = $clog2(RESULT_LIMIT + 1);

  typedef enum logic [OP_W-1:0] {
    OP_READ  = 2'd0,
    OP_WRITE = 2'd1,
    OP_FLUSH = 2'd2,
    OP_NONE  = 2'd3
  } op_e;

  typedef logic [SLOT_W-1:0] slot_t;

  typedef struct packed {
    logic accept;
    logic lk_step;
    logic sweep_step;
    logic emit_acc;
    logic fl_step;
    logic emit_fl;
  } cmd_t;

  typedef struct packed {
    logic lk_done;
    logic lk_match;
    logic lk_free;
    logic sweep_found;
    logic fl_cand;
    logic fl_end;
    logic fl_last;
    logic out_free;
  } status_t;

  typedef struct packed {
    logic                    hit;
    logic [SLOT_FIELD_W-1:0] slot;
    logic                    writeback;
    logic [SECTOR_W-1:0]     writeback_sector;
    logic                    fill;
    logic                    last;
  } rsp_t;

endpackage

// File: src/scct_req_if.sv
// Request channel: operation and sector, valid/ready handshake.
interface scct_req_if;
  import scct_pkg::*;

  logic                valid;
  logic                ready;
  logic [OP_W-1:0]     operation;
  logic [SECTOR_W-1:0] sector;

  modport source (output valid, output operation, output sector, input ready);
  modport sink   (input valid, input operation, input sector, output ready);
endinterface

// File: src/scct_rsp_if.sv
// Result channel: lookup/eviction/flush result, valid/ready handshake.
interface scct_rsp_if;
  import scct_pkg::*;

  logic                    valid;
  logic                    ready;
  logic                    hit;
  logic [SLOT_FIELD_W-1:0] slot;
  logic                    writeback;
  logic [SECTOR_W-1:0]     writeback_sector;
  logic                    fill;
  logic                    last;

  modport source (output valid, output hit, output slot, output writeback,
                  output writeback_sector, output fill, output last, input ready);
  modport sink   (input valid, input hit, input slot, input writeback,
                  input writeback_sector, input fill, input last, output ready);
endinterface

// File: src/scct_ctrl.sv
// Controller state machine: sequences lookup, clock sweep, result and flush steps.
module scct_ctrl (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      req_valid_i,
  input  logic [scct_pkg::OP_W-1:0] req_op_i,
  output logic                      req_ready_o,
  input  scct_pkg::status_t         status_i,
  output scct_pkg::cmd_t            cmd_o
);
  import scct_pkg::*;

  typedef enum logic [5:0] {
    ST_IDLE     = 6'b000001,
    ST_LOOKUP   = 6'b000010,
    ST_SWEEP    = 6'b000100,
    ST_EMIT_ACC = 6'b001000,
    ST_FL_SCAN  = 6'b010000,
    ST_FL_EMIT  = 6'b100000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    req_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        req_ready_o  = 1'b1;
        cmd_o.accept = req_valid_i;
        if (req_valid_i) begin
          case (op_e'(req_op_i))
            OP_READ, OP_WRITE: state_d = ST_LOOKUP;
            OP_FLUSH:          state_d = ST_FL_SCAN;
            default:           state_d = ST_IDLE;
          endcase
        end
      end
      ST_LOOKUP: begin
        cmd_o.lk_step = 1'b1;
        if (status_i.lk_done) begin
          if (status_i.lk_match || status_i.lk_free) state_d = ST_EMIT_ACC;
          else                                       state_d = ST_SWEEP;
        end
      end
      ST_SWEEP: begin
        cmd_o.sweep_step = 1'b1;
        if (status_i.sweep_found) state_d = ST_EMIT_ACC;
      end
      ST_EMIT_ACC: begin
        cmd_o.emit_acc = 1'b1;
        if (status_i.out_free) state_d = ST_IDLE;
      end
      ST_FL_SCAN: begin
        cmd_o.fl_step = 1'b1;
        if (status_i.fl_cand)     state_d = ST_FL_EMIT;
        else if (status_i.fl_end) state_d = ST_IDLE;
      end
      ST_FL_EMIT: begin
        cmd_o.emit_fl = 1'b1;
        if (status_i.out_free) begin
          state_d = status_i.fl_last ? ST_IDLE : ST_FL_SCAN;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

`ifndef SYNTH
  // at most one datapath operation per cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd_o.accept, cmd_o.lk_step, cmd_o.sweep_step,
              cmd_o.emit_acc, cmd_o.fl_step, cmd_o.emit_fl}))
    else $error("scct_ctrl: overlapping datapath commands");
`endif

endmodule

// File: src/scct_dp.sv
// Datapath: tag memory, slot state bits, clock hand, scan counters, result register.
module scct_dp (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  scct_pkg::cmd_t                cmd_i,
  output scct_pkg::status_t             status_o,
  input  logic [scct_pkg::OP_W-1:0]     req_op_i,
  input  logic [scct_pkg::SECTOR_W-1:0] req_sector_i,
  input  logic                          rsp_ready_i,
  output logic                          rsp_valid_o,
  output scct_pkg::rsp_t                rsp_o
);
  import scct_pkg::*;

  // tag memory, no reset: an entry is only looked at while its valid bit is set
  logic [SECTOR_W-1:0] mem [SLOTS];
  logic [SECTOR_W-1:0] rd_data_q;
  logic                mem_re, mem_we;
  slot_t               rd_addr;

  logic [SECTOR_W-1:0] sector_q;
  logic                write_q;

  logic [SLOTS-1:0] valid_q, valid_d, dirty_q, dirty_d, ref_q, ref_d;
  slot_t            hand_q, hand_d, idx_q, idx_d, cmp_idx_q, cmp_idx_d;
  slot_t            hit_slot_q, hit_slot_d, free_slot_q, free_slot_d, vict_q, vict_d;
  logic             issue_q, issue_d, cmp_vld_q, cmp_vld_d;
  logic             hit_q, hit_d, free_q, free_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             rsp_vld_q, rsp_vld_d;
  rsp_t             rsp_q, rsp_d;

  logic             cmp_match, cmp_empty, sweep_found, fl_cand, fl_last, rest_any;
  logic             out_free, acc_fire, fl_fire, evict;
  logic [SLOTS-1:0] above;
  slot_t            hand_next, idx_next, acc_slot;

  assign hand_next   = (hand_q == slot_t'(SLOTS - 1)) ? '0 : hand_q + 1'b1;
  assign idx_next    = (idx_q == slot_t'(SLOTS - 1)) ? '0 : idx_q + 1'b1;
  assign cmp_match   = cmp_vld_q && valid_q[cmp_idx_q] && (rd_data_q == sector_q);
  assign cmp_empty   = cmp_vld_q && !valid_q[cmp_idx_q];
  assign sweep_found = !valid_q[hand_q] || !ref_q[hand_q];
  assign fl_cand     = valid_q[idx_q] && dirty_q[idx_q];

  always_comb begin
    for (int j = 0; j < SLOTS; j++) begin
      above[j] = (slot_t'(j) > idx_q);
    end
  end

  assign rest_any = |(valid_q & dirty_q & above);
  assign fl_last  = !rest_any || (cnt_q == CNT_W'(RESULT_LIMIT - 1));
  assign out_free = !rsp_vld_q || rsp_ready_i;
  assign acc_fire = cmd_i.emit_acc && out_free;
  assign fl_fire  = cmd_i.emit_fl && out_free;
  assign evict    = !hit_q && !free_q;
  assign acc_slot = hit_q ? hit_slot_q : (free_q ? free_slot_q : vict_q);

  assign mem_re  = (cmd_i.lk_step && issue_q) || (cmd_i.sweep_step && sweep_found) ||
                   (cmd_i.fl_step && fl_cand);
  assign rd_addr = cmd_i.sweep_step ? hand_q : idx_q;
  assign mem_we  = acc_fire && !hit_q;

  always_comb begin
    valid_d     = valid_q;
    dirty_d     = dirty_q;
    ref_d       = ref_q;
    hand_d      = hand_q;
    idx_d       = idx_q;
    cmp_idx_d   = cmp_idx_q;
    hit_slot_d  = hit_slot_q;
    free_slot_d = free_slot_q;
    vict_d      = vict_q;
    issue_d     = issue_q;
    cmp_vld_d   = cmp_vld_q;
    hit_d       = hit_q;
    free_d      = free_q;
    cnt_d       = cnt_q;
    rsp_d       = rsp_q;

    if (cmd_i.accept) begin
      idx_d     = '0;
      issue_d   = 1'b1;
      cmp_vld_d = 1'b0;
      hit_d     = 1'b0;
      free_d    = 1'b0;
      cnt_d     = '0;
    end

    // lookup: read one tag per cycle, compare it the cycle after
    if (cmd_i.lk_step) begin
      cmp_vld_d = issue_q;
      cmp_idx_d = idx_q;
      if (issue_q) begin
        issue_d = (idx_q != slot_t'(SLOTS - 1));
        idx_d   = idx_next;
      end
      if (cmp_match && !hit_q) begin
        hit_d      = 1'b1;
        hit_slot_d = cmp_idx_q;
      end
      if (cmp_empty && !free_q) begin
        free_d      = 1'b1;
        free_slot_d = cmp_idx_q;
      end
    end

    // clock sweep: one slot per cycle
    if (cmd_i.sweep_step) begin
      hand_d = hand_next;
      if (sweep_found) vict_d = hand_q;
      else             ref_d[hand_q] = 1'b0;
    end

    if (acc_fire) begin
      ref_d[acc_slot] = 1'b1;
      if (hit_q) begin
        if (write_q) dirty_d[acc_slot] = 1'b1;
      end else begin
        valid_d[acc_slot] = 1'b1;
        dirty_d[acc_slot] = write_q;
      end
      rsp_d.hit              = hit_q;
      rsp_d.slot             = SLOT_FIELD_W'(acc_slot);
      rsp_d.writeback        = evict;
      rsp_d.writeback_sector = evict ? rd_data_q : '0;
      rsp_d.fill             = !hit_q;
      rsp_d.last             = 1'b1;
    end

    if (cmd_i.fl_step && !fl_cand) idx_d = idx_next;

    if (fl_fire) begin
      dirty_d[idx_q]         = 1'b0;
      cnt_d                  = cnt_q + 1'b1;
      idx_d                  = idx_next;
      rsp_d.hit              = 1'b0;
      rsp_d.slot             = SLOT_FIELD_W'(idx_q);
      rsp_d.writeback        = 1'b1;
      rsp_d.writeback_sector = rd_data_q;
      rsp_d.fill             = 1'b0;
      rsp_d.last             = fl_last;
    end

    if (acc_fire || fl_fire) rsp_vld_d = 1'b1;
    else if (rsp_ready_i)    rsp_vld_d = 1'b0;
    else                     rsp_vld_d = rsp_vld_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q   <= '0;
      dirty_q   <= '0;
      ref_q     <= '1;
      hand_q    <= '0;
      idx_q     <= '0;
      cmp_idx_q <= '0;
      issue_q   <= 1'b0;
      cmp_vld_q <= 1'b0;
      hit_q     <= 1'b0;
      free_q    <= 1'b0;
      cnt_q     <= '0;
      rsp_vld_q <= 1'b0;
    end else begin
      valid_q   <= valid_d;
      dirty_q   <= dirty_d;
      ref_q     <= ref_d;
      hand_q    <= hand_d;
      idx_q     <= idx_d;
      cmp_idx_q <= cmp_idx_d;
      issue_q   <= issue_d;
      cmp_vld_q <= cmp_vld_d;
      hit_q     <= hit_d;
      free_q    <= free_d;
      cnt_q     <= cnt_d;
      rsp_vld_q <= rsp_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hit_slot_q  <= hit_slot_d;
    free_slot_q <= free_slot_d;
    vict_q      <= vict_d;
    rsp_q       <= rsp_d;
    if (cmd_i.accept) begin
      sector_q <= req_sector_i;
      write_q  <= (op_e'(req_op_i) == OP_WRITE);
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[acc_slot] <= sector_q;
    if (mem_re) rd_data_q <= mem[rd_addr];
  end

  assign rsp_valid_o = rsp_vld_q;
  assign rsp_o       = rsp_q;

  assign status_o.lk_done     = !issue_q && !cmp_vld_q;
  assign status_o.lk_match    = hit_q;
  assign status_o.lk_free     = free_q;
  assign status_o.sweep_found = sweep_found;
  assign status_o.fl_cand     = fl_cand;
  assign status_o.fl_end      = (idx_q == slot_t'(SLOTS - 1));
  assign status_o.fl_last     = fl_last;
  assign status_o.out_free    = out_free;

`ifndef SYNTH
  // the sweep only runs with every slot occupied
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.sweep_step |-> &valid_q)
    else $error("scct_dp: clock sweep with an empty slot");

  // a fill leaves its slot valid
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc_fire && !hit_q) |=> valid_q[$past(acc_slot)])
    else $error("scct_dp: filled slot not valid");

  // flush never exceeds its result budget
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fl_fire |-> (cnt_q < CNT_W'(RESULT_LIMIT)))
    else $error("scct_dp: flush result limit exceeded");
`endif

endmodule

// File: src/sector_cache_clock_tags.sv
// Top level of the sector cache tag and clock replacement engine.
//
//  channel  | dir | transaction carries
//  ---------+-----+----------------------------------------------------------
//  req_i    | in  | operation (read/write/flush), sector
//  rsp_o    | out | hit, slot, writeback, writeback_sector, fill, last
//
// Sequence: a read or write scans all SLOTS tags from the single read port of
//   the tag memory, one per cycle, before a hit or a fill into an empty slot
//   gives its result; a full cache adds a clock sweep to pick a victim. A
//   flush scans the slots and writes back each dirty slot that it finds.
// Reset: no clearing pass; valid/dirty/reference bits and the hand reset at
//   once and the tag memory is left unset.
// Stalls: a held result parks the engine in its emit step; the next request
//   is taken as soon as the last result is registered.
module sector_cache_clock_tags (
  input  logic       clk_i,
  input  logic       rst_ni,
  scct_req_if.sink   req_i,
  scct_rsp_if.source rsp_o
);
  import scct_pkg::*;

  cmd_t    cmd;
  status_t status;
  rsp_t    rsp;
  logic    rsp_valid;

  // controller owns sequencing; datapath owns all slot state
  scct_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_op_i    (req_i.operation),
    .req_ready_o (req_i.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  scct_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .status_o     (status),
    .req_op_i     (req_i.operation),
    .req_sector_i (req_i.sector),
    .rsp_ready_i  (rsp_o.ready),
    .rsp_valid_o  (rsp_valid),
    .rsp_o        (rsp)
  );

  // result register straight onto the channel
  assign rsp_o.valid            = rsp_valid;
  assign rsp_o.hit              = rsp.hit;
  assign rsp_o.slot             = rsp.slot;
  assign rsp_o.writeback        = rsp.writeback;
  assign rsp_o.writeback_sector = rsp.writeback_sector;
  assign rsp_o.fill             = rsp.fill;
  assign rsp_o.last             = rsp.last;

endmodule
